// ===== sv/cbsat_pkg.sv =====
// ============================================================================
// cbsat_pkg
// Shared widths and types for the circle versus box separating axis test.
// ============================================================================
package cbsat_pkg;

    localparam int COORD_W   = 16;   // signed coordinates
    localparam int SIZE_W    = 14;   // radius and half sizes
    localparam int CORNER_W  = 17;   // box corner coordinate
    localparam int DIFF_W    = 18;   // corner minus circle centre
    localparam int MAG_W     = 17;   // magnitude of a difference
    localparam int D2_W      = 34;   // squared distance
    localparam int SHIFT_SQ  = 28;   // radicand is d2 shifted by this
    localparam int RAD_W     = D2_W + SHIFT_SQ;
    localparam int ROOT_W    = 31;   // floored root, 14 fraction bits
    localparam int REM_W     = 34;
    localparam int NUM_SHIFT = 29;
    localparam int NUM_W     = 47;   // dividend of the normaliser
    localparam int DIV_W     = 32;   // twice the length
    localparam int QUO_W     = 15;   // normal magnitude
    localparam int NORM_W    = 16;
    localparam int NORM_BITS = 14;
    localparam int PROD_W    = 32;
    localparam int SPROD_W   = 29;
    localparam int ACC_W     = 36;
    localparam int DEPTH_W   = 17;
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = 17'h1FFFF;

    typedef struct packed {
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic        [SIZE_W-1:0]  r;
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] by;
        logic        [SIZE_W-1:0]  hw;
        logic        [SIZE_W-1:0]  hh;
    } geom_t;

    typedef struct packed {
        logic             zero;
        logic             neg_x;
        logic             neg_y;
        logic [MAG_W-1:0] mag_x;
        logic [MAG_W-1:0] mag_y;
    } axis_t;

endpackage

// ===== sv/circle_box_separating_axis_test.sv =====
// ============================================================================
// circle_box_separating_axis_test
// Circle against axis-aligned box on the axis towards the nearest box corner:
// hit flag, unit normal (Q1.14) and overlap depth.
// ============================================================================
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  input   | in_valid / in_stall  | circle_x circle_y circle_radius box_x
//          |                      | box_y box_half_width box_half_height
//  output  | out_valid / out_stall| hit normal_x normal_y overlap_depth
//
//  one transfer per cycle in, one per cycle out while no result is held
//  most of the pipe is the bit-per-stage square root (31 stages) and the
//  bit-per-stage normaliser divider (15 stages)
//  reset clears only the stage valid bits
//  a held result at the output freezes the whole pipe and raises in_stall
//
module circle_box_separating_axis_test
    import cbsat_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic signed [COORD_W-1:0] circle_x,
    input  logic signed [COORD_W-1:0] circle_y,
    input  logic        [SIZE_W-1:0]  circle_radius,
    input  logic signed [COORD_W-1:0] box_x,
    input  logic signed [COORD_W-1:0] box_y,
    input  logic        [SIZE_W-1:0]  box_half_width,
    input  logic        [SIZE_W-1:0]  box_half_height,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      hit,
    output logic signed [NORM_W-1:0]  normal_x,
    output logic signed [NORM_W-1:0]  normal_y,
    output logic        [DEPTH_W-1:0] overlap_depth
);

    logic en;
    geom_t in_geom;

    // global advance: the pipe moves unless a result is held
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    assign in_geom = '{cx: circle_x, cy: circle_y, r: circle_radius,
                       bx: box_x, by: box_y, hw: box_half_width,
                       hh: box_half_height};

    // ------------------------------------------------------------------
    // stage 1: box corners
    // ------------------------------------------------------------------
    logic                       s1_valid_reg;
    geom_t                      s1_geom_reg;
    logic signed [CORNER_W-1:0] s1_kxp_reg, s1_kxm_reg, s1_kyp_reg, s1_kym_reg;
    logic signed [CORNER_W-1:0] s1_kxp_next, s1_kxm_next, s1_kyp_next, s1_kym_next;

    always_comb
    begin
        s1_kxp_next = CORNER_W'(box_x) + $signed({3'b000, box_half_width});
        s1_kxm_next = CORNER_W'(box_x) - $signed({3'b000, box_half_width});
        s1_kyp_next = CORNER_W'(box_y) + $signed({3'b000, box_half_height});
        s1_kym_next = CORNER_W'(box_y) - $signed({3'b000, box_half_height});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (en)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_geom_reg <= in_geom;
            s1_kxp_reg  <= s1_kxp_next;
            s1_kxm_reg  <= s1_kxm_next;
            s1_kyp_reg  <= s1_kyp_next;
            s1_kym_reg  <= s1_kym_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: nearest corner, plus side wins an x tie, the x side wins a y tie
    // ------------------------------------------------------------------
    logic         s2_valid_reg;
    geom_t        s2_geom_reg;
    axis_t        s2_axis_reg, s2_axis_next;
    logic signed [DIFF_W-1:0] dxp, dxm, dyp, dym, dxs, dys;
    logic [DIFF_W-1:0] axp_w, axm_w, ayp_w, aym_w, abx_w, aby_w;
    logic [MAG_W-1:0]  axp, axm, ayp, aym;
    logic              xs_plus, ys_plus;

    always_comb
    begin
        dxp = DIFF_W'(s1_kxp_reg) - DIFF_W'(s1_geom_reg.cx);
        dxm = DIFF_W'(s1_kxm_reg) - DIFF_W'(s1_geom_reg.cx);
        dyp = DIFF_W'(s1_kyp_reg) - DIFF_W'(s1_geom_reg.cy);
        dym = DIFF_W'(s1_kym_reg) - DIFF_W'(s1_geom_reg.cy);
        axp_w = dxp[DIFF_W-1] ? -dxp : dxp;
        axm_w = dxm[DIFF_W-1] ? -dxm : dxm;
        ayp_w = dyp[DIFF_W-1] ? -dyp : dyp;
        aym_w = dym[DIFF_W-1] ? -dym : dym;
        axp = axp_w[MAG_W-1:0];
        axm = axm_w[MAG_W-1:0];
        ayp = ayp_w[MAG_W-1:0];
        aym = aym_w[MAG_W-1:0];
        xs_plus = (axp <= axm);
        ys_plus = xs_plus ? (ayp <= aym) : (ayp < aym);
        dxs = xs_plus ? dxp : dxm;
        dys = ys_plus ? dyp : dym;
        abx_w = xs_plus ? axp_w : axm_w;
        aby_w = ys_plus ? ayp_w : aym_w;
        s2_axis_next.zero  = 1'b0;
        s2_axis_next.neg_x = dxs[DIFF_W-1];
        s2_axis_next.neg_y = dys[DIFF_W-1];
        s2_axis_next.mag_x = abx_w[MAG_W-1:0];
        s2_axis_next.mag_y = aby_w[MAG_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (en)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_geom_reg <= s1_geom_reg;
            s2_axis_reg <= s2_axis_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: squares
    // ------------------------------------------------------------------
    logic              s3_valid_reg;
    geom_t             s3_geom_reg;
    axis_t             s3_axis_reg;
    logic [D2_W-1:0]   s3_sqx_reg, s3_sqy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (en)
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_geom_reg <= s2_geom_reg;
            s3_axis_reg <= s2_axis_reg;
            s3_sqx_reg  <= D2_W'(s2_axis_reg.mag_x) * D2_W'(s2_axis_reg.mag_x);
            s3_sqy_reg  <= D2_W'(s2_axis_reg.mag_y) * D2_W'(s2_axis_reg.mag_y);
        end
    end

    // ------------------------------------------------------------------
    // square root pipe: entry 0 holds the squared length, one root bit
    // per stage after that
    // ------------------------------------------------------------------
    logic              sr_valid_reg [0:ROOT_W];
    geom_t             sr_geom_reg  [0:ROOT_W];
    axis_t             sr_axis_reg  [0:ROOT_W];
    logic [D2_W-1:0]   sr_d2_reg    [0:ROOT_W];
    logic [ROOT_W-1:0] sr_root_reg  [0:ROOT_W];
    logic [REM_W-1:0]  sr_rem_reg   [0:ROOT_W];
    logic [ROOT_W-1:0] sr_root_next [0:ROOT_W-1];
    logic [REM_W-1:0]  sr_rem_next  [0:ROOT_W-1];
    logic [D2_W-1:0]   sum_d2;
    axis_t             s4_axis;

    always_comb
    begin
        sum_d2       = s3_sqx_reg + s3_sqy_reg;
        s4_axis      = s3_axis_reg;
        s4_axis.zero = (sum_d2 == '0);
    end

    // one digit of the square root per stage
    always_comb
    begin
        logic [RAD_W-1:0] rad;
        logic [REM_W-1:0] rsh;
        logic [REM_W-1:0] trial;
        for (int j = 0; j < ROOT_W; j++)
        begin
            rad   = {sr_d2_reg[j], SHIFT_SQ'(0)};
            rsh   = {sr_rem_reg[j][REM_W-3:0], rad[RAD_W-1-2*j -: 2]};
            trial = {1'b0, sr_root_reg[j], 2'b01};
            if (rsh >= trial)
            begin
                sr_rem_next[j]  = rsh - trial;
                sr_root_next[j] = {sr_root_reg[j][ROOT_W-2:0], 1'b1};
            end
            else
            begin
                sr_rem_next[j]  = rsh;
                sr_root_next[j] = {sr_root_reg[j][ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j <= ROOT_W; j++)
                sr_valid_reg[j] <= 1'b0;
        end
        else if (en)
        begin
            sr_valid_reg[0] <= s3_valid_reg;
            for (int j = 0; j < ROOT_W; j++)
                sr_valid_reg[j+1] <= sr_valid_reg[j];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sr_geom_reg[0] <= s3_geom_reg;
            sr_axis_reg[0] <= s4_axis;
            sr_d2_reg[0]   <= sum_d2;
            sr_root_reg[0] <= '0;
            sr_rem_reg[0]  <= '0;
            for (int j = 0; j < ROOT_W; j++)
            begin
                sr_geom_reg[j+1] <= sr_geom_reg[j];
                sr_axis_reg[j+1] <= sr_axis_reg[j];
                sr_d2_reg[j+1]   <= sr_d2_reg[j];
                sr_root_reg[j+1] <= sr_root_next[j];
                sr_rem_reg[j+1]  <= sr_rem_next[j];
            end
        end
    end

    // ------------------------------------------------------------------
    // normaliser divide pipe: entry 0 holds dividends and divisor,
    // one quotient bit per stage after that, both axes side by side
    // ------------------------------------------------------------------
    logic              dv_valid_reg [0:QUO_W];
    geom_t             dv_geom_reg  [0:QUO_W];
    axis_t             dv_axis_reg  [0:QUO_W];
    logic [DIV_W-1:0]  dv_d_reg     [0:QUO_W];
    logic [NUM_W-1:0]  dv_rx_reg    [0:QUO_W];
    logic [NUM_W-1:0]  dv_ry_reg    [0:QUO_W];
    logic [QUO_W-1:0]  dv_qx_reg    [0:QUO_W];
    logic [QUO_W-1:0]  dv_qy_reg    [0:QUO_W];
    logic [NUM_W-1:0]  dv_rx_next   [0:QUO_W-1];
    logic [NUM_W-1:0]  dv_ry_next   [0:QUO_W-1];
    logic [QUO_W-1:0]  dv_qx_next   [0:QUO_W-1];
    logic [QUO_W-1:0]  dv_qy_next   [0:QUO_W-1];
    logic [ROOT_W-1:0] len;
    axis_t             sr_last_axis;

    assign len          = sr_root_reg[ROOT_W];
    assign sr_last_axis = sr_axis_reg[ROOT_W];

    // restoring division, one bit per stage
    always_comb
    begin
        logic [NUM_W-1:0] cmp;
        for (int j = 0; j < QUO_W; j++)
        begin
            cmp = NUM_W'(dv_d_reg[j]) << (QUO_W - 1 - j);
            if (dv_rx_reg[j] >= cmp)
            begin
                dv_rx_next[j] = dv_rx_reg[j] - cmp;
                dv_qx_next[j] = {dv_qx_reg[j][QUO_W-2:0], 1'b1};
            end
            else
            begin
                dv_rx_next[j] = dv_rx_reg[j];
                dv_qx_next[j] = {dv_qx_reg[j][QUO_W-2:0], 1'b0};
            end
            if (dv_ry_reg[j] >= cmp)
            begin
                dv_ry_next[j] = dv_ry_reg[j] - cmp;
                dv_qy_next[j] = {dv_qy_reg[j][QUO_W-2:0], 1'b1};
            end
            else
            begin
                dv_ry_next[j] = dv_ry_reg[j];
                dv_qy_next[j] = {dv_qy_reg[j][QUO_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j <= QUO_W; j++)
                dv_valid_reg[j] <= 1'b0;
        end
        else if (en)
        begin
            dv_valid_reg[0] <= sr_valid_reg[ROOT_W];
            for (int j = 0; j < QUO_W; j++)
                dv_valid_reg[j+1] <= dv_valid_reg[j];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_geom_reg[0] <= sr_geom_reg[ROOT_W];
            dv_axis_reg[0] <= sr_last_axis;
            dv_d_reg[0]    <= {len, 1'b0};
            dv_rx_reg[0]   <= {sr_last_axis.mag_x, NUM_SHIFT'(0)} + NUM_W'(len);
            dv_ry_reg[0]   <= {sr_last_axis.mag_y, NUM_SHIFT'(0)} + NUM_W'(len);
            dv_qx_reg[0]   <= '0;
            dv_qy_reg[0]   <= '0;
            for (int j = 0; j < QUO_W; j++)
            begin
                dv_geom_reg[j+1] <= dv_geom_reg[j];
                dv_axis_reg[j+1] <= dv_axis_reg[j];
                dv_d_reg[j+1]    <= dv_d_reg[j];
                dv_rx_reg[j+1]   <= dv_rx_next[j];
                dv_ry_reg[j+1]   <= dv_ry_next[j];
                dv_qx_reg[j+1]   <= dv_qx_next[j];
                dv_qy_reg[j+1]   <= dv_qy_next[j];
            end
        end
    end

    // ------------------------------------------------------------------
    // signed normal
    // ------------------------------------------------------------------
    logic                     ns_valid_reg;
    geom_t                    ns_geom_reg;
    logic                     ns_zero_reg;
    logic [QUO_W-1:0]         ns_qx_reg, ns_qy_reg;
    logic signed [NORM_W-1:0] ns_nx_reg, ns_ny_reg, ns_nx_next, ns_ny_next;
    axis_t                    dv_last_axis;
    logic [QUO_W-1:0]         qx_fin, qy_fin;

    always_comb
    begin
        dv_last_axis = dv_axis_reg[QUO_W];
        qx_fin       = dv_last_axis.zero ? '0 : dv_qx_reg[QUO_W];
        qy_fin       = dv_last_axis.zero ? '0 : dv_qy_reg[QUO_W];
        ns_nx_next   = dv_last_axis.neg_x ? -$signed({1'b0, qx_fin})
                                          :  $signed({1'b0, qx_fin});
        ns_ny_next   = dv_last_axis.neg_y ? -$signed({1'b0, qy_fin})
                                          :  $signed({1'b0, qy_fin});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ns_valid_reg <= 1'b0;
        else if (en)
            ns_valid_reg <= dv_valid_reg[QUO_W];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ns_geom_reg <= dv_geom_reg[QUO_W];
            ns_zero_reg <= dv_last_axis.zero;
            ns_qx_reg   <= qx_fin;
            ns_qy_reg   <= qy_fin;
            ns_nx_reg   <= ns_nx_next;
            ns_ny_reg   <= ns_ny_next;
        end
    end

    // ------------------------------------------------------------------
    // projection products
    // ------------------------------------------------------------------
    logic                      pm_valid_reg;
    logic                      pm_zero_reg;
    logic [SIZE_W-1:0]         pm_r_reg;
    logic signed [NORM_W-1:0]  pm_nx_reg, pm_ny_reg;
    logic signed [PROD_W-1:0]  pm_bx_reg, pm_by_reg, pm_cx_reg, pm_cy_reg;
    logic [SPROD_W-1:0]        pm_hw_reg, pm_hh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pm_valid_reg <= 1'b0;
        else if (en)
            pm_valid_reg <= ns_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pm_zero_reg <= ns_zero_reg;
            pm_r_reg    <= ns_geom_reg.r;
            pm_nx_reg   <= ns_nx_reg;
            pm_ny_reg   <= ns_ny_reg;
            pm_bx_reg   <= PROD_W'(ns_geom_reg.bx) * PROD_W'(ns_nx_reg);
            pm_by_reg   <= PROD_W'(ns_geom_reg.by) * PROD_W'(ns_ny_reg);
            pm_cx_reg   <= PROD_W'(ns_geom_reg.cx) * PROD_W'(ns_nx_reg);
            pm_cy_reg   <= PROD_W'(ns_geom_reg.cy) * PROD_W'(ns_ny_reg);
            pm_hw_reg   <= SPROD_W'(ns_geom_reg.hw) * SPROD_W'(ns_qx_reg);
            pm_hh_reg   <= SPROD_W'(ns_geom_reg.hh) * SPROD_W'(ns_qy_reg);
        end
    end

    // ------------------------------------------------------------------
    // box centre, box extent, circle centre and radius on the axis
    // ------------------------------------------------------------------
    logic                     ps_valid_reg;
    logic                     ps_zero_reg;
    logic signed [NORM_W-1:0] ps_nx_reg, ps_ny_reg;
    logic signed [ACC_W-1:0]  ps_c_reg, ps_e_reg, ps_cp_reg, ps_rr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ps_valid_reg <= 1'b0;
        else if (en)
            ps_valid_reg <= pm_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ps_zero_reg <= pm_zero_reg;
            ps_nx_reg   <= pm_nx_reg;
            ps_ny_reg   <= pm_ny_reg;
            ps_c_reg    <= ACC_W'(pm_bx_reg) + ACC_W'(pm_by_reg);
            ps_cp_reg   <= ACC_W'(pm_cx_reg) + ACC_W'(pm_cy_reg);
            ps_e_reg    <= $signed(ACC_W'(pm_hw_reg) + ACC_W'(pm_hh_reg));
            ps_rr_reg   <= $signed(ACC_W'(pm_r_reg) << NORM_BITS);
        end
    end

    // ------------------------------------------------------------------
    // interval intersection
    // ------------------------------------------------------------------
    logic                     pe_valid_reg;
    logic                     pe_zero_reg;
    logic signed [NORM_W-1:0] pe_nx_reg, pe_ny_reg;
    logic signed [ACC_W-1:0]  pe_end_reg, pe_beg_reg, pe_end_next, pe_beg_next;
    logic signed [ACC_W-1:0]  box_hi, box_lo, cir_hi, cir_lo;

    always_comb
    begin
        box_hi      = ps_c_reg + ps_e_reg;
        box_lo      = ps_c_reg - ps_e_reg;
        cir_hi      = ps_cp_reg + ps_rr_reg;
        cir_lo      = ps_cp_reg - ps_rr_reg;
        pe_end_next = (box_hi < cir_hi) ? box_hi : cir_hi;
        pe_beg_next = (box_lo > cir_lo) ? box_lo : cir_lo;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pe_valid_reg <= 1'b0;
        else if (en)
            pe_valid_reg <= ps_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pe_zero_reg <= ps_zero_reg;
            pe_nx_reg   <= ps_nx_reg;
            pe_ny_reg   <= ps_ny_reg;
            pe_end_reg  <= pe_end_next;
            pe_beg_reg  <= pe_beg_next;
        end
    end

    // ------------------------------------------------------------------
    // output register: hit, rounded and saturated depth
    // ------------------------------------------------------------------
    logic                     out_valid_reg;
    logic                     hit_reg, hit_next;
    logic signed [NORM_W-1:0] nx_out_reg, ny_out_reg;
    logic [DEPTH_W-1:0]       depth_reg, depth_next;
    logic signed [ACC_W-1:0]  ovl, ovl_rnd;
    logic [ACC_W-NORM_BITS-1:0] ovl_sh;

    always_comb
    begin
        ovl      = pe_end_reg - pe_beg_reg;
        ovl_rnd  = ovl + ACC_W'(1 << (NORM_BITS - 1));
        ovl_sh   = ovl_rnd[ACC_W-1:NORM_BITS];
        hit_next = !pe_zero_reg && !ovl[ACC_W-1];
        if (!hit_next)
            depth_next = '0;
        else if (ovl_sh > (ACC_W-NORM_BITS)'(DEPTH_MAX))
            depth_next = DEPTH_MAX;
        else
            depth_next = ovl_sh[DEPTH_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= pe_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg    <= hit_next;
            nx_out_reg <= pe_nx_reg;
            ny_out_reg <= pe_ny_reg;
            depth_reg  <= depth_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign hit           = hit_reg;
    assign normal_x      = nx_out_reg;
    assign normal_y      = ny_out_reg;
    assign overlap_depth = depth_reg;

endmodule
